// File: hdl/dasp_pkg.sv
package dasp_pkg;

  localparam int unsigned POSITION_LIMIT_DEF = 4096;
  localparam int unsigned TICK_BITS_DEF      = 10;
  localparam int unsigned SPAN_HARD_MAX      = 4096;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned SPAN_W  = 13;
  localparam int unsigned TICKS_W = 10;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS     = 2'd2;

  localparam logic [SPAN_W-1:0]  STEPS_PER_REV_RST = 13'd200;
  localparam logic [TICKS_W-1:0] HIGH_TICKS_RST    = 10'd10;
  localparam logic [TICKS_W-1:0] LOW_TICKS_RST     = 10'd10;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             dir;
    logic             step;
  } axis_dec_t;

endpackage

// File: hdl/dasp_axis.sv
module dasp_axis (
  input  logic [dasp_pkg::POS_W-1:0]  pos_i,
  input  logic [dasp_pkg::POS_W-1:0]  tgt_i,
  input  logic [dasp_pkg::SPAN_W-1:0] span_i,
  input  logic                        last_dir_i,
  output dasp_pkg::axis_dec_t         dec_o
);

  logic [dasp_pkg::SPAN_W-1:0] p;
  logic [dasp_pkg::SPAN_W-1:0] t;
  logic [dasp_pkg::SPAN_W-1:0] cw;
  logic [dasp_pkg::SPAN_W-1:0] ccw;
  logic [dasp_pkg::SPAN_W-1:0] p_inc;
  logic [dasp_pkg::SPAN_W-1:0] p_dec;
  logic [dasp_pkg::SPAN_W-1:0] p_new;
  logic                        dir;
  logic                        step;

  always_comb begin
    p = {1'b0, pos_i};
    if (p >= span_i) begin
      p = span_i - 1'b1;
    end
    t = {1'b0, tgt_i};
    // circular distances, sum stays below 2 * span so 13 bits wrap cleanly
    cw  = t + span_i - p;
    if (cw >= span_i) begin
      cw = cw - span_i;
    end
    ccw = p + span_i - t;
    if (ccw >= span_i) begin
      ccw = ccw - span_i;
    end

    dir  = last_dir_i;
    step = 1'b1;
    if (cw < ccw) begin
      dir = 1'b1;
    end else if (cw > ccw) begin
      dir = 1'b0;
    end else if (cw == '0) begin
      dir  = 1'b0;
      step = 1'b0;
    end

    p_inc = (p + 1'b1 == span_i) ? '0 : p + 1'b1;
    p_dec = (p == '0) ? span_i - 1'b1 : p - 1'b1;
    if (!step) begin
      p_new = p;
    end else if (dir) begin
      p_new = p_inc;
    end else begin
      p_new = p_dec;
    end

    dec_o.pos  = p_new[dasp_pkg::POS_W-1:0];
    dec_o.dir  = dir;
    dec_o.step = step;
  end

endmodule

// File: hdl/dual_axis_stepper_shortest_path_top.sv
// Two-axis step/direction controller on a circular position space. Every input
// item is one timer tick; every accepted item yields exactly one result item,
// shown on the master side the cycle after acceptance. The block takes one item
// per clock: all work for a tick is done by the logic ahead of the single result
// register, and s_axis_tready_o stays high while that register is empty or being
// taken. At each step period start both targets are sampled and each axis moves
// one step the shorter way round (a tie keeps the last direction); the step pin
// is high for high_ticks ticks, then low for low_ticks ticks. A load item
// overwrites both positions without restarting the period. Out-of-range targets
// and loads are clamped to span - 1 and flagged in range_error.
module dual_axis_stepper_shortest_path_top #(
  parameter int unsigned POSITION_LIMIT = dasp_pkg::POSITION_LIMIT_DEF,
  parameter int unsigned TICK_BITS      = dasp_pkg::TICK_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dasp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dasp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // roll_target, pitch_target, roll_load_value, pitch_load_value
  input  logic [dasp_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // load_position
  input  logic [dasp_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // roll direction, roll step, pitch direction, pitch step, roll_position,
  // pitch_position, roll_at_target, pitch_at_target, range_error, 1 pad bit
  output logic [dasp_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned SPAN_MAX = (POSITION_LIMIT > dasp_pkg::SPAN_HARD_MAX) ?
                                     dasp_pkg::SPAN_HARD_MAX : POSITION_LIMIT;
  localparam int unsigned LIM_W    = ((TICK_BITS > dasp_pkg::TICKS_W) ?
                                      TICK_BITS : dasp_pkg::TICKS_W) + 1;
  localparam logic [LIM_W-1:0] TICK_MAX = LIM_W'((64'd1 << TICK_BITS) - 64'd1);

  localparam int unsigned PW = dasp_pkg::POS_W;
  localparam int unsigned SW = dasp_pkg::SPAN_W;

  function automatic logic [PW:0] clamp_pos(input logic [PW-1:0] v,
                                            input logic [SW-1:0] n);
    logic [PW:0] r;
    if ({1'b0, v} >= n) begin
      r = {1'b1, PW'(n - 1'b1)};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  function automatic logic [TICK_BITS-1:0] tick_limit(
    input logic [dasp_pkg::TICKS_W-1:0] t);
    logic [LIM_W-1:0] v;
    v = LIM_W'(t);
    if (v == '0) begin
      v = LIM_W'(1);
    end
    if (v > TICK_MAX) begin
      v = TICK_MAX;
    end
    return v[TICK_BITS-1:0];
  endfunction

  // configuration
  logic [SW-1:0]                steps_q;
  logic [dasp_pkg::TICKS_W-1:0] high_q;
  logic [dasp_pkg::TICKS_W-1:0] low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= dasp_pkg::STEPS_PER_REV_RST;
      high_q  <= dasp_pkg::HIGH_TICKS_RST;
      low_q   <= dasp_pkg::LOW_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dasp_pkg::REG_STEPS_PER_REV: steps_q <= cfg_wdata_i[SW-1:0];
        dasp_pkg::REG_HIGH_TICKS:    high_q  <= cfg_wdata_i[dasp_pkg::TICKS_W-1:0];
        dasp_pkg::REG_LOW_TICKS:     low_q   <= cfg_wdata_i[dasp_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic [PW-1:0]        rpos_q, rpos_d, ppos_q, ppos_d;
  logic [PW-1:0]        rtgt_q, rtgt_d, ptgt_q, ptgt_d;
  logic                 rdir_q, rdir_d, pdir_q, pdir_d;
  logic                 rstep_q, rstep_d, pstep_q, pstep_d;
  logic [1:0]           phase_q, phase_d;
  logic [TICK_BITS-1:0] ticks_q, ticks_d;

  logic                          out_valid_q;
  logic [dasp_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic        in_acc;
  logic [SW-1:0] span;
  logic        load;
  logic [PW:0] rld_c, pld_c, rtg_c, ptg_c;
  logic [PW-1:0] rpos_a, ppos_a;
  logic        start;
  logic        err;
  logic        step_high;
  logic [TICK_BITS:0] cnt_inc;
  dasp_pkg::axis_dec_t rdec, pdec;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    span = steps_q;
    if (span < SW'(2)) begin
      span = SW'(2);
    end
    if (span > SW'(SPAN_MAX)) begin
      span = SW'(SPAN_MAX);
    end
  end

  assign load  = s_axis_tuser_i[0];
  assign rld_c = clamp_pos(s_axis_tdata_i[35:24], span);
  assign pld_c = clamp_pos(s_axis_tdata_i[47:36], span);
  assign rtg_c = clamp_pos(s_axis_tdata_i[11:0], span);
  assign ptg_c = clamp_pos(s_axis_tdata_i[23:12], span);

  assign rpos_a = load ? rld_c[PW-1:0] : rpos_q;
  assign ppos_a = load ? pld_c[PW-1:0] : ppos_q;
  assign start  = (phase_q != dasp_pkg::PH_HIGH) && (phase_q != dasp_pkg::PH_LOW);

  dasp_axis u_roll (
    .pos_i      (rpos_a),
    .tgt_i      (rtg_c[PW-1:0]),
    .span_i     (span),
    .last_dir_i (rdir_q),
    .dec_o      (rdec)
  );

  dasp_axis u_pitch (
    .pos_i      (ppos_a),
    .tgt_i      (ptg_c[PW-1:0]),
    .span_i     (span),
    .last_dir_i (pdir_q),
    .dec_o      (pdec)
  );

  always_comb begin
    rpos_d  = start ? rdec.pos  : rpos_a;
    ppos_d  = start ? pdec.pos  : ppos_a;
    rdir_d  = start ? rdec.dir  : rdir_q;
    pdir_d  = start ? pdec.dir  : pdir_q;
    rstep_d = start ? rdec.step : rstep_q;
    pstep_d = start ? pdec.step : pstep_q;
    rtgt_d  = start ? rtg_c[PW-1:0] : rtgt_q;
    ptgt_d  = start ? ptg_c[PW-1:0] : ptgt_q;

    err = (load && (rld_c[PW] || pld_c[PW])) ||
          (start && (rtg_c[PW] || ptg_c[PW]));

    step_high = start || (phase_q == dasp_pkg::PH_HIGH);
    cnt_inc   = start ? (TICK_BITS+1)'(1) : {1'b0, ticks_q} + 1'b1;

    phase_d = start ? dasp_pkg::PH_HIGH : phase_q;
    ticks_d = cnt_inc[TICK_BITS-1:0];
    if (step_high) begin
      if (cnt_inc >= {1'b0, tick_limit(high_q)}) begin
        phase_d = dasp_pkg::PH_LOW;
        ticks_d = '0;
      end
    end else if (cnt_inc >= {1'b0, tick_limit(low_q)}) begin
      phase_d = dasp_pkg::PH_IDLE;
      ticks_d = '0;
    end

    out_data_d = {1'b0,
                  err,
                  (ppos_d == ptgt_d),
                  (rpos_d == rtgt_d),
                  ppos_d,
                  rpos_d,
                  step_high && pstep_d,
                  pdir_d,
                  step_high && rstep_d,
                  !rdir_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpos_q  <= '0;
      ppos_q  <= '0;
      rtgt_q  <= '0;
      ptgt_q  <= '0;
      rdir_q  <= 1'b0;
      pdir_q  <= 1'b0;
      rstep_q <= 1'b0;
      pstep_q <= 1'b0;
      phase_q <= dasp_pkg::PH_IDLE;
      ticks_q <= '0;
    end else if (in_acc) begin
      rpos_q  <= rpos_d;
      ppos_q  <= ppos_d;
      rtgt_q  <= rtgt_d;
      ptgt_q  <= ptgt_d;
      rdir_q  <= rdir_d;
      pdir_q  <= pdir_d;
      rstep_q <= rstep_d;
      pstep_q <= pstep_d;
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: hdl/dasp_checker.sv
module dasp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [dasp_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result item changed");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted item produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("empty output register not ready");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o) && !(m_axis_tvalid_o && !m_axis_tready_i)
    |=> !m_axis_tvalid_o)
    else $error("result item without input item");

endmodule

bind dual_axis_stepper_shortest_path_top dasp_checker u_dasp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PW = dasp_pkg::POS_W;

  typedef struct packed {
    logic          load;
    logic [PW-1:0] pitch_load;
    logic [PW-1:0] roll_load;
    logic [PW-1:0] pitch_tgt;
    logic [PW-1:0] roll_tgt;
  } tick_t;

  typedef struct packed {
    logic          pad;
    logic          range_err;
    logic          pitch_at;
    logic          roll_at;
    logic [PW-1:0] pitch_pos;
    logic [PW-1:0] roll_pos;
    logic          pitch_step;
    logic          pitch_sense;
    logic          roll_step;
    logic          roll_sense;
  } pins_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [dasp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dasp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            s_valid;
  logic                            s_ready;
  logic [dasp_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [dasp_pkg::IN_USER_W-1:0]  s_tuser;
  logic                            m_valid;
  logic                            m_ready;
  logic [dasp_pkg::OUT_DATA_W-1:0] m_tdata;

  dual_axis_stepper_shortest_path_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  // motor model state
  logic [dasp_pkg::SPAN_W-1:0]  spr_q;
  logic [dasp_pkg::TICKS_W-1:0] high_q, low_q;
  logic [PW-1:0]                roll_pos_q, pitch_pos_q, roll_tgt_q, pitch_tgt_q;
  bit                           roll_cw_q, pitch_cw_q, roll_run_q, pitch_run_q;
  logic [1:0]                   phase_q;
  int                           phase_cnt_q;

  tick_t pending_ticks[$];
  pins_t expected_pins[$];
  tick_t cur_tick;
  pins_t want, got;

  bit tick_taken;
  int snd_gap, rcv_gap, snd_pct, rcv_pct;
  int errors, ticks_checked, pulses_seen, clamps_seen, settings_used;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int circle();
    int n, lim;
    lim = (dasp_pkg::POSITION_LIMIT_DEF < dasp_pkg::SPAN_HARD_MAX) ?
          dasp_pkg::POSITION_LIMIT_DEF : dasp_pkg::SPAN_HARD_MAX;
    if (lim < 2) lim = 2;
    n = int'(spr_q);
    if (n < 2) n = 2;
    if (n > lim) n = lim;
    return n;
  endfunction

  function automatic int hold(logic [dasp_pkg::TICKS_W-1:0] t);
    return (t == 0) ? 1 : int'(t);
  endfunction

  function automatic logic [PW-1:0] fit(int v, int n, inout bit err);
    if (v >= n) begin
      err = 1'b1;
      return PW'(n - 1);
    end
    return PW'(v);
  endfunction

  // one axis at period start: shorter way round, tie keeps direction
  function automatic bit steer(inout logic [PW-1:0] pos, input logic [PW-1:0] tgt,
                               input int n, inout bit cw);
    int p, t, cwd, ccwd;
    if (int'(pos) >= n) pos = PW'(n - 1);
    p = int'(pos);
    t = int'(tgt);
    cwd = (t + n - p) % n;
    ccwd = (p + n - t) % n;
    if (cwd < ccwd) cw = 1'b1;
    else if (cwd > ccwd) cw = 1'b0;
    else if (cwd == 0) begin
      cw = 1'b0;
      return 1'b0;
    end
    pos = PW'(cw ? (p + 1) % n : (p + n - 1) % n);
    return 1'b1;
  endfunction

  function automatic pins_t step_motors(tick_t t);
    int n;
    bit err;
    pins_t r;
    n = circle();
    err = 1'b0;
    if (t.load) begin
      roll_pos_q = fit(int'(t.roll_load), n, err);
      pitch_pos_q = fit(int'(t.pitch_load), n, err);
    end
    if (phase_q != dasp_pkg::PH_HIGH && phase_q != dasp_pkg::PH_LOW) begin
      roll_tgt_q = fit(int'(t.roll_tgt), n, err);
      pitch_tgt_q = fit(int'(t.pitch_tgt), n, err);
      roll_run_q = steer(roll_pos_q, roll_tgt_q, n, roll_cw_q);
      pitch_run_q = steer(pitch_pos_q, pitch_tgt_q, n, pitch_cw_q);
      phase_q = dasp_pkg::PH_HIGH;
      phase_cnt_q = 0;
    end
    r = '0;
    r.roll_sense = !roll_cw_q;
    r.roll_step = (phase_q == dasp_pkg::PH_HIGH) && roll_run_q;
    r.pitch_sense = pitch_cw_q;
    r.pitch_step = (phase_q == dasp_pkg::PH_HIGH) && pitch_run_q;
    r.roll_pos = roll_pos_q;
    r.pitch_pos = pitch_pos_q;
    r.roll_at = (roll_pos_q == roll_tgt_q);
    r.pitch_at = (pitch_pos_q == pitch_tgt_q);
    r.range_err = err;
    phase_cnt_q++;
    if (phase_q == dasp_pkg::PH_HIGH) begin
      if (phase_cnt_q >= hold(high_q)) begin
        phase_q = dasp_pkg::PH_LOW;
        phase_cnt_q = 0;
      end
    end else if (phase_cnt_q >= hold(low_q)) begin
      phase_q = dasp_pkg::PH_IDLE;
      phase_cnt_q = 0;
    end
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // input side bookkeeping and output checks
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tick_taken = s_valid && s_ready;
      if (tick_taken) expected_pins.push_back(step_motors(cur_tick));
      if (m_valid && m_ready) begin
        got = pins_t'(m_tdata);
        if (expected_pins.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected, actual %h", $time, m_tdata);
        end else begin
          want = expected_pins.pop_front();
          ticks_checked++;
          if (got.roll_step || got.pitch_step) pulses_seen++;
          if (got.range_err) clamps_seen++;
          check_field("roll direction", want.roll_sense, got.roll_sense);
          check_field("roll step", want.roll_step, got.roll_step);
          check_field("pitch direction", want.pitch_sense, got.pitch_sense);
          check_field("pitch step", want.pitch_step, got.pitch_step);
          check_field("roll_position", want.roll_pos, got.roll_pos);
          check_field("pitch_position", want.pitch_pos, got.pitch_pos);
          check_field("roll_at_target", want.roll_at, got.roll_at);
          check_field("pitch_at_target", want.pitch_at, got.pitch_at);
          check_field("range_error", want.range_err, got.range_err);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(s_valid && !tick_taken)) begin
      if (snd_gap > 0) begin
        snd_gap--;
        s_valid <= 1'b0;
      end else if (pending_ticks.size() > 0 && $urandom_range(0, 99) < snd_pct) begin
        snd_gap = $urandom_range(0, 16);
        s_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        cur_tick = pending_ticks.pop_front();
        s_valid <= 1'b1;
        s_tdata <= {cur_tick.pitch_load, cur_tick.roll_load, cur_tick.pitch_tgt,
                    cur_tick.roll_tgt};
        s_tuser <= cur_tick.load;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rcv_gap > 0) begin
        rcv_gap--;
        m_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rcv_pct) begin
        rcv_gap = $urandom_range(0, 16);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_put(logic [dasp_pkg::CFG_IDX_W-1:0] idx,
                         logic [dasp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      dasp_pkg::REG_STEPS_PER_REV: spr_q = val;
      dasp_pkg::REG_HIGH_TICKS:    high_q = val[dasp_pkg::TICKS_W-1:0];
      dasp_pkg::REG_LOW_TICKS:     low_q = val[dasp_pkg::TICKS_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_tick(int rt, int pt, bit ld, int rl, int pl);
    tick_t t;
    t.roll_tgt = PW'(rt);
    t.pitch_tgt = PW'(pt);
    t.load = ld;
    t.roll_load = PW'(rl);
    t.pitch_load = PW'(pl);
    pending_ticks.push_back(t);
  endtask

  function automatic logic [PW-1:0] pick_pos(int n, logic [PW-1:0] prev);
    int r, p, d;
    r = $urandom_range(0, 9);
    p = int'(prev);
    d = $urandom_range(0, 8);
    if (r < 2) return PW'($urandom_range(0, 4095));
    if (r < 5) return PW'((p + n + d - 4) % n);
    return PW'($urandom_range(0, n - 1));
  endfunction

  // targets held for stretches so axes actually arrive; loads and jumps as noise
  task automatic random_ticks(int count);
    int n;
    logic [PW-1:0] rt, pt;
    bit ld;
    n = circle();
    rt = PW'($urandom_range(0, n - 1));
    pt = PW'($urandom_range(0, n - 1));
    repeat (count) begin
      if ($urandom_range(0, 23) == 0) rt = pick_pos(n, rt);
      if ($urandom_range(0, 23) == 0) pt = pick_pos(n, pt);
      ld = ($urandom_range(0, 11) == 0);
      add_tick(int'(rt), int'(pt), ld, int'(pick_pos(n, rt)), int'(pick_pos(n, pt)));
    end
  endtask

  task automatic set_idling(bit calm);
    if (calm) begin
      snd_pct = 0;
      rcv_pct = 0;
      snd_gap = 0;
      rcv_gap = 0;
    end else begin
      snd_pct = $urandom_range(0, 2) * 15;
      rcv_pct = $urandom_range(0, 2) * 15;
    end
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || expected_pins.size() != 0 || s_valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [dasp_pkg::CFG_DATA_W-1:0] spr,
                           logic [dasp_pkg::CFG_DATA_W-1:0] hi,
                           logic [dasp_pkg::CFG_DATA_W-1:0] lo, int count, bit calm);
    cfg_put(dasp_pkg::REG_STEPS_PER_REV, spr);
    cfg_put(dasp_pkg::REG_HIGH_TICKS, hi);
    cfg_put(dasp_pkg::REG_LOW_TICKS, lo);
    settings_used++;
    set_idling(calm);
    random_ticks(count);
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_valid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_ready = 1'b0;
    spr_q = dasp_pkg::STEPS_PER_REV_RST;
    high_q = dasp_pkg::HIGH_TICKS_RST;
    low_q = dasp_pkg::LOW_TICKS_RST;
    roll_pos_q = '0;
    pitch_pos_q = '0;
    roll_tgt_q = '0;
    pitch_tgt_q = '0;
    roll_cw_q = 1'b0;
    pitch_cw_q = 1'b0;
    roll_run_q = 1'b0;
    pitch_run_q = 1'b0;
    phase_q = dasp_pkg::PH_IDLE;
    phase_cnt_q = 0;
    tick_taken = 1'b0;
    snd_gap = 0;
    rcv_gap = 0;
    errors = 0;
    ticks_checked = 0;
    pulses_seen = 0;
    clamps_seen = 0;
    settings_used = 1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings
    set_idling(1'b0);
    add_tick(3, 197, 0, 0, 0);
    add_tick(3, 197, 0, 0, 0);
    add_tick(0, 0, 1, 199, 1);
    add_tick(0, 0, 0, 0, 0);
    settle();

    cfg_put(dasp_pkg::REG_HIGH_TICKS, 1);
    cfg_put(dasp_pkg::REG_LOW_TICKS, 1);
    settings_used++;
    set_idling(1'b0);
    add_tick(0, 0, 1, 0, 0);          // on target
    add_tick(0, 0, 0, 0, 0);
    add_tick(100, 100, 0, 0, 0);      // half circle tie
    add_tick(100, 100, 0, 0, 0);
    add_tick(4095, 4095, 0, 0, 0);    // target clamp
    add_tick(4095, 4095, 0, 0, 0);
    add_tick(199, 199, 1, 4095, 4095); // load clamp
    add_tick(199, 199, 0, 0, 0);
    add_tick(0, 0, 0, 0, 0);          // wrap clockwise
    add_tick(0, 0, 0, 0, 0);
    add_tick(3, 197, 1, 5, 195);
    add_tick(3, 197, 0, 0, 0);
    add_tick(3, 197, 0, 0, 0);
    add_tick(0, 250, 1, 250, 0);
    add_tick(0, 250, 0, 0, 0);
    add_tick(150, 50, 1, 0, 0);
    add_tick(150, 50, 1, 0, 0);       // load in both phases
    add_tick(150, 50, 0, 0, 0);
    add_tick(100, 100, 1, 100, 100);
    add_tick('hAAA, 'h555, 1, 'h555, 'hAAA);
    add_tick('h555, 'hAAA, 0, 'hFFF, 'hFFF);
    settle();

    run_phase(4096, 1, 2, 250, 1'b0);
    run_phase(2, 1, 1, 150, 1'b0);
    run_phase(8191, 0, 0, 200, 1'b0);   // clamps to full circle, zero ticks act as one
    run_phase(0, 3, 1, 100, 1'b0);
    run_phase(1, 2, 3, 60, 1'b0);
    run_phase(7, 1023, 1023, 40, 1'b0);
    run_phase(4097, 'h1C05, 2, 150, 1'b0); // clamps to full circle
    run_phase(13, 1, 1, 200, 1'b0);        // shrinks circle below stale positions
    run_phase(4096, 2, 1, 420, 1'b1);

    repeat (8) @(posedge clk_i);
    $display("Checked %0d ticks over %0d register settings, circle sizes 2 to 4096,",
             ticks_checked, settings_used);
    $display("with %0d step pulses and %0d clamped ticks seen.", pulses_seen, clamps_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
